>>> sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/mwd_pkg.sv
// Types and constants of the memory window descriptor register bank.
package mwd_pkg;

	localparam int WINDOWS          = 16;
	localparam int MIRRORED_WINDOWS = 4;

	localparam int IDX_W     = $clog2(2 * WINDOWS) > 0 ? $clog2(2 * WINDOWS) : 1;
	localparam int REG_DEPTH = 1 << IDX_W;

	localparam logic [4:0] WIN_COUNT    = 5'(WINDOWS);
	localparam logic [4:0] MIRROR_COUNT = 5'(MIRRORED_WINDOWS);

	localparam logic [31:0] BASE_ADDR_BITS = 32'hFFFF_F000;
	localparam logic [31:0] INITIATOR_BITS = 32'h0000_00F0;
	localparam logic [31:0] ROUTING_BITS   = 32'h0000_000C;
	localparam logic [31:0] READ_ONLY_BIT  = 32'h0000_0002;
	localparam logic [31:0] ENABLE_BIT     = 32'h0000_0001;
	localparam logic [31:0] BASE_KEEP      = BASE_ADDR_BITS | INITIATOR_BITS | ROUTING_BITS
		| READ_ONLY_BIT | ENABLE_BIT;
	localparam logic [31:0] LIMIT_KEEP     = 32'hFFFF_FFF8;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SIZE  = 2'd2,
		ST_CROSS = 2'd3
	} status_t;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		SIZE_BYTE = 3'd1,
		SIZE_HALF = 3'd2,
		SIZE_WORD = 3'd4
	} size_t_e_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} rd_req_t;

endpackage

>>> sv/mwd_if.sv
// Request and response channel interfaces of the descriptor register bank.
interface mwd_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  address;
	logic [2:0]  access_size;
	logic [31:0] write_data;

	modport source (output valid, command, address, access_size, write_data, input ready);
	modport sink (input valid, command, address, access_size, write_data, output ready);
endinterface

interface mwd_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [1:0]  status;
	logic        mirror_valid;
	logic [1:0]  mirror_window;
	logic [31:0] mirror_base;

	modport source (output valid, read_data, status, mirror_valid, mirror_window, mirror_base,
		input ready);
	modport sink (input valid, read_data, status, mirror_valid, mirror_window, mirror_base,
		output ready);
endinterface

>>> sv/memory_window_descriptor_regs.sv
// Top level of the memory window descriptor register bank.
// An accepted request is held in stage 1, then its result in the output register.
// Throughput: one transaction per cycle unless the response stalls; the store is read at
// acceptance and written back from stage 1, with the written word forwarded to the next access.
// Reset: arst_n clears all entry valid bits at once, so every descriptor reads zero;
// no clearing pass, requests are taken in the first cycle after reset.
module memory_window_descriptor_regs
	import mwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mwd_req_if.sink   req,
	mwd_rsp_if.source rsp
);

	logic        s1_v_q;
	logic        cmd_s1;
	logic [7:0]  addr_s1;
	logic [2:0]  size_s1;
	logic [31:0] wdata_s1;
	logic        fwd_hit_s1;
	logic [31:0] fwd_word_s1;

	logic        out_v_q;
	logic [31:0] rdata_q;
	status_t     status_q;
	logic        mvalid_q;
	logic [1:0]  mwin_q;
	logic [31:0] mbase_q;

	rd_req_t     rd;
	wr_req_t     wr;
	logic [31:0] mem_rdata;

	logic        accept;
	logic        s1_adv;
	logic [4:0]  win;
	logic [1:0]  offset;
	logic [4:0]  shamt;
	logic [31:0] mask;
	logic [31:0] word;
	logic [31:0] merged;
	logic [31:0] new_word;
	logic [31:0] rdata_c;
	status_t     status_c;
	logic        mvalid_c;
	logic [1:0]  mwin_c;
	logic [31:0] mbase_c;

	mwd_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.rd_data (mem_rdata),
		.wr      (wr)
	);

	assign s1_adv    = s1_v_q && (!out_v_q || rsp.ready);
	assign req.ready = !s1_v_q || s1_adv;
	assign accept    = req.valid && req.ready;

	assign rd.en  = accept;
	assign rd.idx = req.address[2 +: IDX_W];

	assign win    = addr_s1[7:3];
	assign offset = addr_s1[1:0];
	assign shamt  = {offset, 3'b000};
	assign word   = fwd_hit_s1 ? fwd_word_s1 : mem_rdata;

	always_comb begin
		case (size_s1)
			SIZE_BYTE: mask = 32'h0000_00FF;
			SIZE_HALF: mask = 32'h0000_FFFF;
			default:   mask = 32'hFFFF_FFFF;
		endcase
	end

	always_comb begin
		status_c = ST_OK;
		if (win >= WIN_COUNT) begin
			status_c = ST_RANGE;
		end else if (!(size_s1 inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD})) begin
			status_c = ST_SIZE;
		end else if (({2'b00, offset} + {1'b0, size_s1}) > 4'd4) begin
			status_c = ST_CROSS;
		end
	end

	always_comb begin
		merged   = (word & ~(mask << shamt)) | ((wdata_s1 & mask) << shamt);
		new_word = merged & (addr_s1[2] ? LIMIT_KEEP : BASE_KEEP);
		rdata_c  = '0;
		mvalid_c = 1'b0;
		mwin_c   = '0;
		mbase_c  = '0;
		wr.en    = 1'b0;
		wr.idx   = addr_s1[2 +: IDX_W];
		wr.data  = new_word;
		if (s1_v_q && status_c == ST_OK) begin
			if (cmd_s1 == CMD_READ) begin
				rdata_c = (word >> shamt) & mask;
			end else begin
				wr.en = s1_adv;
				if (!addr_s1[2] && win < MIRROR_COUNT) begin
					mvalid_c = 1'b1;
					mwin_c   = win[1:0];
					mbase_c  = new_word & BASE_ADDR_BITS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q     <= 1'b0;
			fwd_hit_s1 <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (req.ready) begin
				s1_v_q <= req.valid;
			end
			// Forward a write-back that lands on the word being read this edge.
			if (accept) begin
				fwd_hit_s1 <= wr.en && (wr.idx == rd.idx);
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= req.command;
			addr_s1     <= req.address;
			size_s1     <= req.access_size;
			wdata_s1    <= req.write_data;
			fwd_word_s1 <= wr.data;
		end
		if (s1_adv) begin
			rdata_q  <= rdata_c;
			status_q <= status_c;
			mvalid_q <= mvalid_c;
			mwin_q   <= mwin_c;
			mbase_q  <= mbase_c;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.read_data     = rdata_q;
	assign rsp.status        = status_q;
	assign rsp.mirror_valid  = mvalid_q;
	assign rsp.mirror_window = mwin_q;
	assign rsp.mirror_base   = mbase_q;

endmodule

>>> sv/mwd_regfile.sv
// Descriptor word store: synchronous memory with registered read and per-entry valid bits.
module mwd_regfile
	import mwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rd_req_t     rd,
	output logic [31:0] rd_data,
	input  wr_req_t     wr
);

	logic [31:0]          mem [REG_DEPTH];
	logic [REG_DEPTH-1:0] vld_q;
	logic [31:0]          rd_word_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd.en) begin
			rd_word_q <= mem[rd.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= vld_q[rd.idx];
			end
		end
	end

	// An entry never written reads as its reset value, zero.
	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

>>> sv/mwd_checker.sv
// Port-level checker of the descriptor register bank, bound to the top level.
`include "assert_macros.svh"

module mwd_checker
	import mwd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_read_data,
	input logic [1:0]  rsp_status,
	input logic        rsp_mirror_valid,
	input logic [31:0] rsp_mirror_base
);

	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_SAME(a_rsp_drop, $fell(rsp_valid), $past(rsp_ready))
	`ASSERT_SAME(a_err_quiet, rsp_valid && rsp_status != ST_OK, rsp_read_data == '0 && !rsp_mirror_valid)
	`ASSERT_SAME(a_mirror_aligned, rsp_valid && rsp_mirror_valid, rsp_mirror_base[11:0] == '0 && rsp_read_data == '0)

endmodule

bind memory_window_descriptor_regs mwd_checker u_mwd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_read_data    (rsp.read_data),
	.rsp_status       (rsp.status),
	.rsp_mirror_valid (rsp.mirror_valid),
	.rsp_mirror_base  (rsp.mirror_base)
);

>>> tb/mwd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the descriptor bank: predicts each bus access and compares the responses.
module mwd_scoreboard
	import mwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mwd_req_if   req,
	mwd_rsp_if   rsp,
	output int   fails,
	output int   pending
);

	typedef struct packed {
		logic [31:0] read_data;
		status_t     status;
		logic        mirror_valid;
		logic [1:0]  mirror_window;
		logic [31:0] mirror_base;
	} access_result_t;

	logic [31:0]    desc_words [REG_DEPTH];
	access_result_t expected_results [$];

	function automatic access_result_t predict_access(cmd_t cmd, logic [7:0] addr,
		logic [2:0] size, logic [31:0] wdata);
		access_result_t res;
		logic [4:0]     win;
		logic [1:0]     off;
		logic [4:0]     widx;
		logic [31:0]    mask;
		logic [31:0]    word;
		int             shift;
		res   = '0;
		win   = addr[7:3];
		off   = addr[1:0];
		widx  = addr[6:2];
		shift = int'(off) * 8;
		if (int'(win) >= WINDOWS) begin
			res.status = ST_RANGE;
		end else if (size != SIZE_BYTE && size != SIZE_HALF && size != SIZE_WORD) begin
			res.status = ST_SIZE;
		end else if (int'(off) + int'(size) > 4) begin
			res.status = ST_CROSS;
		end else begin
			res.status = ST_OK;
			mask = (size == SIZE_BYTE) ? 32'h0000_00FF :
				(size == SIZE_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
			word = desc_words[widx];
			if (cmd == CMD_READ) begin
				res.read_data = (word >> shift) & mask;
			end else begin
				word = (word & ~(mask << shift)) | ((wdata & mask) << shift);
				// bit 2 of the address picks the limit word
				if (!addr[2]) begin
					word &= BASE_KEEP;
					if (int'(win) < MIRRORED_WINDOWS) begin
						res.mirror_valid  = 1'b1;
						res.mirror_window = win[1:0];
						res.mirror_base   = word & BASE_ADDR_BITS;
					end
				end else begin
					word &= LIMIT_KEEP;
				end
				desc_words[widx] = word;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t got;
		access_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < REG_DEPTH; i++) desc_words[i] = '0;
			expected_results.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.read_data     = rsp.read_data;
				got.status        = status_t'(rsp.status);
				got.mirror_valid  = rsp.mirror_valid;
				got.mirror_window = rsp.mirror_window;
				got.mirror_base   = rsp.mirror_base;
				if (expected_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected response transaction: read_data %h status %0d",
							got.read_data, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.read_data !== want.read_data || got.status !== want.status
						|| got.mirror_valid !== want.mirror_valid
						|| got.mirror_window !== want.mirror_window
						|| got.mirror_base !== want.mirror_base) begin
						fails++;
						if (fails <= 10)
							$display({"mismatch (expected/actual): read_data %h/%h status %0d/%0d",
								" mirror %b/%b window %0d/%0d base %h/%h"},
								want.read_data, got.read_data, want.status, got.status,
								want.mirror_valid, got.mirror_valid,
								want.mirror_window, got.mirror_window,
								want.mirror_base, got.mirror_base);
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(predict_access(cmd_t'(req.command), req.address,
					req.access_size, req.write_data));
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives bus accesses into the descriptor bank and reports the verdict.
module testbench;
	import mwd_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int RANDOM_PER_PHASE = 175;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	logic hold_off_go;
	int   fails;
	int   pending;
	int   cycle_count = 0;

	mwd_req_if req();
	mwd_rsp_if rsp();

	memory_window_descriptor_regs u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mwd_scoreboard u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("memory_window_descriptor_regs test failed");
			$finish;
		end
	end

	// Response side: random stalls plus one long hold-off on request.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go && !hold_done) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [7:0] reg_addr(int win, bit limit, int off);
		return {5'(win), limit, 2'(off)};
	endfunction

	// Hold valid across back-to-back transactions; only drop it for an idle cycle.
	task automatic issue_access(cmd_t cmd, logic [7:0] addr, logic [2:0] size,
		logic [31:0] data);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.command     <= cmd;
		req.address     <= addr;
		req.access_size <= size;
		req.write_data  <= data;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic random_access();
		cmd_t        cmd;
		logic [7:0]  addr;
		logic [2:0]  size;
		logic [31:0] data;
		int          off;
		cmd  = cmd_t'($urandom_range(1));
		data = $urandom();
		if ($urandom_range(7) == 0) data = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(2))
				0: begin
					size = SIZE_BYTE;
					off  = $urandom_range(3);
				end
				1: begin
					size = SIZE_HALF;
					off  = 2 * $urandom_range(1);
				end
				default: begin
					size = SIZE_WORD;
					off  = 0;
				end
			endcase
			addr = reg_addr(int'($urandom_range(WINDOWS - 1)), 1'($urandom_range(1)), off);
		end else begin
			// raw fields: out-of-range windows, bad sizes, crossing accesses
			addr = 8'($urandom_range(255));
			size = 3'($urandom_range(7));
		end
		issue_access(cmd, addr, size, data);
	endtask

	initial begin : stimulus
		arst_n          = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		hold_off_go     = 1'b0;
		req.valid       = 1'b0;
		req.command     = CMD_READ;
		req.address     = '0;
		req.access_size = SIZE_WORD;
		req.write_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue_access(CMD_READ, reg_addr(0, 0, 0), SIZE_WORD, '0);
		issue_access(CMD_WRITE, reg_addr(0, 0, 0), SIZE_WORD, 32'hFFFF_FFFF);
		issue_access(CMD_READ, reg_addr(0, 0, 0), SIZE_WORD, '0);
		issue_access(CMD_WRITE, reg_addr(0, 1, 0), SIZE_WORD, 32'hFFFF_FFFF);
		issue_access(CMD_READ, reg_addr(0, 1, 0), SIZE_BYTE, '0);
		issue_access(CMD_WRITE, reg_addr(3, 0, 1), SIZE_BYTE, 32'h1234_56AB);
		issue_access(CMD_WRITE, reg_addr(3, 0, 2), SIZE_HALF, 32'hFFFF_1234);
		issue_access(CMD_READ, reg_addr(3, 0, 2), SIZE_HALF, '0);
		issue_access(CMD_READ, reg_addr(3, 0, 0), SIZE_WORD, '0);
		issue_access(CMD_WRITE, reg_addr(4, 0, 0), SIZE_WORD, 32'hDEAD_BEEF);
		issue_access(CMD_WRITE, reg_addr(15, 0, 0), SIZE_WORD, 32'h5A5A_5A5A);
		issue_access(CMD_WRITE, reg_addr(15, 1, 0), SIZE_WORD, 32'hA5A5_A5A5);
		issue_access(CMD_READ, reg_addr(15, 1, 3), SIZE_BYTE, '0);
		issue_access(CMD_READ, 8'd128, SIZE_WORD, '0);
		issue_access(CMD_WRITE, 8'hFF, SIZE_BYTE, 32'hFFFF_FFFF);
		for (int s = 0; s < 8; s++)
			if (s != SIZE_BYTE && s != SIZE_HALF && s != SIZE_WORD)
				issue_access(CMD_WRITE, reg_addr(1, 0, 0), 3'(s), 32'hFFFF_FFFF);
		issue_access(CMD_WRITE, reg_addr(1, 0, 3), SIZE_HALF, 32'hFFFF_FFFF);
		issue_access(CMD_READ, reg_addr(1, 1, 2), SIZE_WORD, '0);
		issue_access(CMD_WRITE, reg_addr(1, 0, 1), SIZE_WORD, 32'hFFFF_FFFF);
		issue_access(CMD_READ, reg_addr(1, 0, 0), SIZE_WORD, '0);
		issue_access(CMD_WRITE, reg_addr(7, 1, 0), SIZE_HALF, 32'h0000_FFFF);
		issue_access(CMD_READ, reg_addr(7, 1, 0), SIZE_WORD, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct    = 0;
					stall_pct   = 0;
					hold_off_go = 1'b1;
				end
				1: begin
					idle_pct  = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 83;
				end
				default: begin
					idle_pct  = 37;
					stall_pct = 37;
				end
			endcase
			repeat (RANDOM_PER_PHASE) random_access();
		end

		@(negedge clk);
		req.valid <= 1'b0;
		stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("memory_window_descriptor_regs test passed");
		else
			$display("memory_window_descriptor_regs test failed");
		$finish;
	end

endmodule
